/* rtl/timed_pin_action_sequencer_macros.svh */
// assertion macros for the timed pin action sequencer checker
`ifndef TIMED_PIN_ACTION_SEQUENCER_MACROS_SVH
`define TIMED_PIN_ACTION_SEQUENCER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define TPAS_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication checked outside reset
`define TPAS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

/* rtl/tpas_pkg.sv */
// shared constants and types for the timed pin action sequencer
package tpas_pkg;
   localparam int MAX_ENTRIES = 16;
   localparam int CHANNELS = 8;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_START  = 3'd3;
   localparam logic [2:0] CMD_CANCEL = 3'd4;
   localparam logic [2:0] CMD_SWITCH = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DENIED = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_NONE   = 2'd3;

   // register indexes
   localparam logic [0:0] REG_ROUND_COUNT = 1'd0;
   localparam logic [0:0] REG_ROUND_DELAY = 1'd1;

   // one table entry
   typedef struct packed {
      logic [31:0] tim;
      logic [2:0]  chan;
      logic        lvl;
   } entry_type;
endpackage

/* rtl/timed_pin_action_sequencer.sv */
// top level of the timed pin action sequencer
// Each command gives one response word, shown for one cycle on rsp_valid; the receiver
// cannot stall it. Commands run through a state sequence since the table sits in a memory
// with a registered read port and a separate write port. Clear, cancel, switch, rejected
// commands and ticks outside a run go straight from dispatch to done; a tick in a run reads
// and checks entries in table order until one is not yet due or the table ends; an add does
// two sorted inserts, each a search pass that reads then checks each entry, then a shift
// pass that reads then writes each entry moved. The response strobe comes in the first
// cycle with busy low, and a new command can be taken in that same cycle.
module timed_pin_action_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [2:0]  req_pin,
   input  logic        req_level,
   input  logic [31:0] req_offset,
   input  logic [31:0] req_duration,
   output logic        rsp_valid,
   output logic [7:0]  rsp_pin_out,
   output logic        rsp_busy_res,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_rounds_remaining,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   import tpas_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SEARCH, S_SEARCH_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PLACE,
      S_FIRE_RD, S_FIRE_CHK, S_TICK_END, S_DONE
   } state_type;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_RUN   = 2'd1;
   localparam logic [1:0] PH_PAUSE = 2'd2;

   // table memory
   entry_type mem [MAX_ENTRIES];
   entry_type rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   state_type   state_ff;
   logic [2:0]  cmd_ff;
   logic [2:0]  pin_ff;
   logic        level_ff;
   logic [31:0] t_ins_ff;
   logic [31:0] t_end_ff;
   logic        second_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] cursor_ff;
   logic [31:0] elapsed_ff;
   logic [7:0]  rounds_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  pins_ff;
   logic [7:0]  round_count_ff;
   logic [31:0] round_delay_ff;
   logic [1:0]  status_ff;
   logic        rsp_valid_ff;

   logic [32:0] end_sum;
   logic [31:0] elapsed_inc;
   logic [7:0]  pins_drive;

   assign end_sum = {1'b0, req_offset} + {1'b0, req_duration};
   assign elapsed_inc = (elapsed_ff == 32'hFFFF_FFFF) ? elapsed_ff : elapsed_ff + 32'd1;

   // pin update from the entry just read
   always_comb begin
      pins_drive = pins_ff;
      if (32'(rd_ff.chan) < CHANNELS) pins_drive[rd_ff.chan] = rd_ff.lvl;
   end

   // memory port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   // address and write control
   always_comb begin
      rd_addr = idx_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_ff;
      case (state_ff)
         S_SHIFT_RD: rd_addr = IDX_W'(idx_ff - CNT_W'(1));
         S_SHIFT_WR: wr_en = 1'b1;
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IDX_W-1:0];
            wr_data = '{tim: t_ins_ff, chan: pin_ff, lvl: ~second_ff};
         end
         S_FIRE_RD: rd_addr = cursor_ff[IDX_W-1:0];
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pin_out = pins_ff;
   assign rsp_busy_res = (phase_ff != PH_IDLE);
   assign rsp_status = status_ff;
   assign rsp_rounds_remaining = rounds_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cursor_ff <= '0;
         elapsed_ff <= '0;
         rounds_ff <= '0;
         phase_ff <= PH_IDLE;
         pins_ff <= '0;
         round_count_ff <= '0;
         round_delay_ff <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (csr_valid && csr_ready) begin
                  if (csr_index == REG_ROUND_COUNT) round_count_ff <= csr_data[7:0];
                  else round_delay_ff <= csr_data;
               end
               if (start) begin
                  cmd_ff <= req_cmd;
                  pin_ff <= req_pin;
                  level_ff <= req_level;
                  t_ins_ff <= req_offset;
                  t_end_ff <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
                  second_ff <= 1'b0;
                  status_ff <= ST_OK;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               state_ff <= S_DONE;
               case (cmd_ff)
                  CMD_TICK: begin
                     if (phase_ff == PH_RUN) begin
                        state_ff <= S_FIRE_RD;
                     end else if (phase_ff == PH_PAUSE) begin
                        elapsed_ff <= elapsed_inc;
                        if (elapsed_inc >= round_delay_ff) begin
                           if (rounds_ff != 8'd0) rounds_ff <= rounds_ff - 8'd1;
                           elapsed_ff <= '0;
                           cursor_ff <= '0;
                           phase_ff <= PH_RUN;
                        end
                     end
                  end
                  CMD_ADD: begin
                     if (phase_ff != PH_IDLE) status_ff <= ST_DENIED;
                     else if (32'(count_ff) + 2 > MAX_ENTRIES) status_ff <= ST_FULL;
                     else begin
                        pos_ff <= '0;
                        idx_ff <= '0;
                        state_ff <= S_SEARCH;
                     end
                  end
                  CMD_CLEAR: begin
                     if (phase_ff != PH_IDLE) status_ff <= ST_DENIED;
                     else count_ff <= '0;
                  end
                  CMD_START: begin
                     if (phase_ff != PH_IDLE) status_ff <= ST_DENIED;
                     else if (count_ff == '0 || round_count_ff == 8'd0) status_ff <= ST_NONE;
                     else begin
                        rounds_ff <= round_count_ff - 8'd1;
                        elapsed_ff <= '0;
                        cursor_ff <= '0;
                        phase_ff <= PH_RUN;
                     end
                  end
                  CMD_CANCEL: begin
                     if (phase_ff != PH_IDLE) begin
                        pins_ff <= '0;
                        phase_ff <= PH_IDLE;
                        rounds_ff <= '0;
                        cursor_ff <= '0;
                        elapsed_ff <= '0;
                     end else status_ff <= ST_NONE;
                  end
                  CMD_SWITCH: begin
                     if (phase_ff != PH_IDLE) status_ff <= ST_DENIED;
                     else if (32'(pin_ff) < CHANNELS) pins_ff[pin_ff] <= level_ff;
                  end
                  default: ;
               endcase
            end
            // find first entry whose time exceeds the new one
            S_SEARCH: begin
               if (idx_ff >= count_ff) begin
                  pos_ff <= count_ff;
                  idx_ff <= count_ff;
                  state_ff <= S_SHIFT_RD;
               end else state_ff <= S_SEARCH_CHK;
            end
            S_SEARCH_CHK: begin
               if (rd_ff.tim > t_ins_ff) begin
                  pos_ff <= idx_ff;
                  idx_ff <= count_ff;
                  state_ff <= S_SHIFT_RD;
               end else begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= S_SEARCH;
               end
            end
            // move entries up by one from the top down
            S_SHIFT_RD: begin
               if (idx_ff > pos_ff) state_ff <= S_SHIFT_WR;
               else state_ff <= S_PLACE;
            end
            S_SHIFT_WR: begin
               idx_ff <= idx_ff - CNT_W'(1);
               state_ff <= S_SHIFT_RD;
            end
            S_PLACE: begin
               count_ff <= count_ff + CNT_W'(1);
               if (second_ff) state_ff <= S_DONE;
               else begin
                  second_ff <= 1'b1;
                  t_ins_ff <= t_end_ff;
                  pos_ff <= '0;
                  idx_ff <= '0;
                  state_ff <= S_SEARCH;
               end
            end
            // fire due entries in table order
            S_FIRE_RD: begin
               if (cursor_ff >= count_ff) state_ff <= S_TICK_END;
               else state_ff <= S_FIRE_CHK;
            end
            S_FIRE_CHK: begin
               if (rd_ff.tim <= elapsed_ff) begin
                  pins_ff <= pins_drive;
                  cursor_ff <= cursor_ff + CNT_W'(1);
                  state_ff <= S_FIRE_RD;
               end else state_ff <= S_TICK_END;
            end
            S_TICK_END: begin
               elapsed_ff <= elapsed_inc;
               if (cursor_ff >= count_ff) begin
                  if (rounds_ff == 8'd0) begin
                     phase_ff <= PH_IDLE;
                     cursor_ff <= '0;
                     elapsed_ff <= '0;
                  end else if (round_delay_ff == 32'd0) begin
                     rounds_ff <= rounds_ff - 8'd1;
                     elapsed_ff <= '0;
                     cursor_ff <= '0;
                  end else begin
                     phase_ff <= PH_PAUSE;
                     elapsed_ff <= '0;
                  end
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* rtl/tpas_checker.sv */
// port-level checker for the timed pin action sequencer and its bind
`include "timed_pin_action_sequencer_macros.svh"
module tpas_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_busy_res,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_rounds_remaining,
   input logic       csr_ready
);
   import tpas_pkg::*;
   // a taken command makes the block busy next cycle
   `TPAS_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   // a response with no new command leaves the block free
   `TPAS_ASSERT_NEXT(a_rsp_free, clock, reset, rsp_valid && !start, !busy,
      "busy after response")
   // no config while a command is in flight
   `TPAS_ASSERT_IMP(a_csr_idle, clock, reset, csr_ready, !busy, "csr ready while busy")
   // idle response reports no rounds left
   `TPAS_ASSERT_IMP(a_idle_rounds, clock, reset, rsp_valid && !rsp_busy_res,
      rsp_rounds_remaining == 8'd0, "rounds left while idle")
   // denial only given while running
   `TPAS_ASSERT_IMP(a_denied, clock, reset, rsp_valid && rsp_status == ST_DENIED,
      rsp_busy_res, "denied while idle")
endmodule

bind timed_pin_action_sequencer tpas_checker u_tpas_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_busy_res(rsp_busy_res), .rsp_status(rsp_status),
   .rsp_rounds_remaining(rsp_rounds_remaining), .csr_ready(csr_ready)
);
